// ----- src/bta_pkg.sv -----
package bta_pkg;

	// Number of 16-bit words in the allocation bitmap.
	localparam int WORDS = 16;

	// Bits per bitmap word and the tag split into word index and bit.
	localparam int BITS_PER_WORD = 16;
	localparam int BIT_W         = 4;
	localparam int TAG_W         = 10;
	localparam int GRANT_W       = 8;
	localparam int WIDX_W        = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int TWIDX_W       = TAG_W - BIT_W;

	localparam logic [BITS_PER_WORD-1:0] FULL_WORD = 16'hFFFF;

	// Request codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef logic [BITS_PER_WORD-1:0] word_t;
	typedef logic [WIDX_W-1:0]        widx_t;
	typedef logic [BIT_W-1:0]         bidx_t;

	// Write command from the sequencer to the bitmap storage.
	typedef struct packed {
		logic  en;
		widx_t idx;
		word_t word;
	} map_wr_t;

endpackage

// ----- src/bta_ffz.sv -----
module bta_ffz (
	input  bta_pkg::word_t word,
	output logic           found,
	output bta_pkg::bidx_t bit_idx
);

	// Priority encoder for the lowest clear bit; the highest index is
	// visited first so the lowest clear bit wins.
	always_comb begin
		found   = 1'b0;
		bit_idx = '0;
		for (int i = bta_pkg::BITS_PER_WORD - 1; i >= 0; i--) begin
			if (!word[i]) begin
				found   = 1'b1;
				bit_idx = bta_pkg::BIT_W'(i);
			end
		end
	end

endmodule

// ----- src/bta_map.sv -----
module bta_map (
	input  logic             clk,
	input  logic             arst_n,
	input  bta_pkg::widx_t   rd_idx,
	output bta_pkg::word_t   rd_word,
	input  bta_pkg::map_wr_t wr
);

	bta_pkg::word_t map_q [bta_pkg::WORDS];

	// Bitmap words; reset marks every tag free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bta_pkg::WORDS; i++) begin
				map_q[i] <= '0;
			end
		end else if (wr.en) begin
			map_q[wr.idx] <= wr.word;
		end
	end

	// Single read port, addressed by the sequencer.
	assign rd_word = map_q[rd_idx];

endmodule

// ----- src/bitmap_tag_allocator.sv -----
// Bitmap tag allocator.
// Input channel (in_valid / in_stall) carries one request: opcode selects
// allocate or free, tag names the tag to free. Output channel
// (out_valid / out_stall) returns one transaction per request with status
// and granted_tag. A transaction moves at a clock edge with valid high and
// stall low.
// An allocate walks the bitmap one 16-bit word per cycle through a shared
// find-first-zero unit, from word 0 up, and stops at the first word with
// a free bit, or at the last word (word 15) when the map is full. A free
// reads and rewrites only the word that its tag names.
// in_stall is high while a request is being worked on, so one request is
// taken at a time and the next one can be taken the cycle after the result
// is loaded; a new request is accepted while an earlier result still
// waits in the output register.
// If the receiver stalls, the result stays in the output register and the
// sequencer holds its finished result until the register frees up.
// Reset (arst_n low) clears the bitmap to all free and empties the output.
module bitmap_tag_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [bta_pkg::TAG_W-1:0]    tag,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [bta_pkg::GRANT_W-1:0]  granted_tag
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FREE = 2'd2;

	localparam bta_pkg::widx_t LAST_WIDX = bta_pkg::WIDX_W'(bta_pkg::WORDS - 1);

	logic [1:0]               state_q;
	bta_pkg::widx_t           widx_q;
	logic [bta_pkg::TAG_W-1:0] tag_q;

	bta_pkg::word_t   rd_word;
	bta_pkg::map_wr_t wr;
	logic             ffz_found;
	bta_pkg::bidx_t   ffz_bit;

	logic             in_acc;
	logic             slot_free;
	logic             res_load;
	logic [1:0]       res_status;
	logic [bta_pkg::TAG_W-1:0] res_tag;

	logic [bta_pkg::TWIDX_W-1:0] free_widx;
	logic                        free_valid;
	bta_pkg::bidx_t              free_bit;
	bta_pkg::widx_t              rd_idx;

	logic [1:0]                  status_q;
	logic [bta_pkg::GRANT_W-1:0] granted_q;
	logic                        out_valid_q;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign slot_free = !out_valid_q || !out_stall;

	// Tag split for a free request.
	assign free_widx  = tag_q[bta_pkg::TAG_W-1:bta_pkg::BIT_W];
	assign free_bit   = tag_q[bta_pkg::BIT_W-1:0];
	assign free_valid = ({1'b0, free_widx} < (bta_pkg::TWIDX_W + 1)'(bta_pkg::WORDS));

	// The read port follows the scan index, or the word being freed.
	assign rd_idx = (state_q == S_FREE) ? bta_pkg::WIDX_W'(free_widx) : widx_q;

	bta_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rd_idx),
		.rd_word (rd_word),
		.wr      (wr)
	);

	bta_ffz u_ffz (
		.word    (rd_word),
		.found   (ffz_found),
		.bit_idx (ffz_bit)
	);

	// Result and bitmap update for the current step of the sequencer.
	always_comb begin
		res_load   = 1'b0;
		res_status = bta_pkg::ST_OK;
		res_tag    = '0;
		wr.en      = 1'b0;
		wr.idx     = rd_idx;
		wr.word    = rd_word;
		unique case (state_q)
			S_SCAN: begin
				if (ffz_found) begin
					res_load   = slot_free;
					res_status = bta_pkg::ST_OK;
					res_tag    = (bta_pkg::TAG_W'(widx_q) << bta_pkg::BIT_W) |
						bta_pkg::TAG_W'(ffz_bit);
					wr.en      = slot_free;
					wr.word    = rd_word | (bta_pkg::word_t'(1) << ffz_bit);
				end else if (widx_q == LAST_WIDX) begin
					res_load   = slot_free;
					res_status = bta_pkg::ST_NOSPACE;
				end
			end
			S_FREE: begin
				res_load = slot_free;
				if (free_valid) begin
					res_status = bta_pkg::ST_OK;
					wr.en      = slot_free;
					wr.word    = rd_word & ~(bta_pkg::word_t'(1) << free_bit);
				end else begin
					res_status = bta_pkg::ST_INVALID;
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// Sequencer: take a request, walk the map, finish when the output
	// register can take the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			widx_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						widx_q  <= '0;
						state_q <= (opcode == bta_pkg::OP_FREE) ? S_FREE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end else if (!ffz_found && widx_q != LAST_WIDX) begin
						widx_q <= widx_q + 1'b1;
					end
				end
				S_FREE: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request tag capture.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			tag_q <= tag;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q  <= res_status;
			granted_q <= res_tag[bta_pkg::GRANT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign granted_tag = granted_q;

`ifndef SYNTH
	// An accepted request always starts the sequencer.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("accepted request did not start the sequencer");

	// A full-map answer is given only after the last word was examined.
	a_nospace_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && res_status == bta_pkg::ST_NOSPACE |-> widx_q == LAST_WIDX)
		else $error("no-space reported before the scan reached the last word");

	// A result is never loaded over one the receiver has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !res_load)
		else $error("result loaded over a stalled output transaction");

	// The bitmap is written only when a result is produced.
	a_write_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> res_load)
		else $error("bitmap written without a result");
`endif

endmodule

// ----- tb/sv/bitmap_tag_allocator_checker.sv -----
`timescale 1ns / 1ps

module bitmap_tag_allocator_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        opcode,
	input  logic [bta_pkg::TAG_W-1:0]   tag,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [1:0]                  status,
	input  logic [bta_pkg::GRANT_W-1:0] granted_tag,
	output int                          mismatch_count,
	output int                          grants_pending
);

	typedef struct packed {
		logic [1:0]                  status;
		logic [bta_pkg::GRANT_W-1:0] granted;
	} grant_rec_t;

	// Shadow copy of the used-tag bitmap, one 16-bit word per entry.
	logic [bta_pkg::BITS_PER_WORD-1:0] tag_map [bta_pkg::WORDS];

	// Results predicted for accepted requests, oldest first.
	grant_rec_t pending_grants [$];
	grant_rec_t oldest_grant;
	int         fails = 0;

	// Applies one request to the shadow bitmap and returns the result it should give.
	function automatic grant_rec_t predict_tag_request(logic op,
		logic [bta_pkg::TAG_W-1:0] t);
		grant_rec_t rec;
		bit         found;
		int         widx;
		rec.status  = bta_pkg::ST_OK;
		rec.granted = '0;
		found       = 1'b0;
		if (op == bta_pkg::OP_ALLOC) begin
			// Lowest word first, lowest bit first within a word.
			for (int w = 0; w < bta_pkg::WORDS && !found; w++) begin
				for (int b = 0; b < bta_pkg::BITS_PER_WORD && !found; b++) begin
					if (!tag_map[w][b]) begin
						tag_map[w][b] = 1'b1;
						rec.granted   = bta_pkg::GRANT_W'(w * bta_pkg::BITS_PER_WORD + b);
						found         = 1'b1;
					end
				end
			end
			if (!found) begin
				rec.status = bta_pkg::ST_NOSPACE;
			end
		end else begin
			// A word index past the end of the map is rejected and changes nothing.
			widx = int'(t[bta_pkg::TAG_W-1:bta_pkg::BIT_W]);
			if (widx >= bta_pkg::WORDS) begin
				rec.status = bta_pkg::ST_INVALID;
			end else begin
				tag_map[widx][t[bta_pkg::BIT_W-1:0]] = 1'b0;
			end
		end
		return rec;
	endfunction

	// Results are matched before requests are predicted, since a result taken at
	// an edge always belongs to a request accepted at an earlier edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (tag_map[i]) tag_map[i] = '0;
			pending_grants.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_grants.size() == 0) begin
					$error("result transaction with nothing expected: status %0d granted_tag %0d",
						status, granted_tag);
					fails++;
				end else begin
					oldest_grant = pending_grants.pop_front();
					if (status !== oldest_grant.status) begin
						$error("status: expected %0d, actual %0d", oldest_grant.status, status);
						fails++;
					end
					if (granted_tag !== oldest_grant.granted) begin
						$error("granted_tag: expected %0d, actual %0d",
							oldest_grant.granted, granted_tag);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				pending_grants.push_back(predict_tag_request(opcode, tag));
			end
		end
		mismatch_count <= fails;
		grants_pending <= pending_grants.size();
	end

endmodule

// ----- tb/sv/bitmap_tag_allocator_tb.sv -----
`timescale 1ns / 1ps

module bitmap_tag_allocator_tb;

	localparam int RANDOM_ITEMS = 1700;
	localparam int HOLD_AFTER   = 500;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIXED
	} traffic_mode_t;

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        in_valid    = 1'b0;
	logic                        in_stall;
	logic                        opcode      = bta_pkg::OP_ALLOC;
	logic [bta_pkg::TAG_W-1:0]   tag         = '0;
	logic                        out_valid;
	logic                        out_stall   = 1'b0;
	logic [1:0]                  status;
	logic [bta_pkg::GRANT_W-1:0] granted_tag;

	int mismatch_count;
	int grants_pending;
	int requests_sent = 0;
	int burst_left    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bitmap_tag_allocator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.tag         (tag),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.granted_tag (granted_tag)
	);

	bitmap_tag_allocator_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.tag            (tag),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.granted_tag    (granted_tag),
		.mismatch_count (mismatch_count),
		.grants_pending (grants_pending)
	);

	// Offers one request and waits until it is accepted. Between bursts the
	// valid drops for a random number of cycles.
	task automatic send_request(logic op, logic [bta_pkg::TAG_W-1:0] t);
		in_valid <= 1'b1;
		opcode   <= op;
		tag      <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// Picks a tag to release: mostly one inside the map, sometimes past its end.
	function automatic logic [bta_pkg::TAG_W-1:0] pick_free_tag(int valid_pct);
		if ($urandom_range(99) < valid_pct) begin
			return bta_pkg::TAG_W'($urandom_range(bta_pkg::WORDS * bta_pkg::BITS_PER_WORD - 1));
		end
		return bta_pkg::TAG_W'($urandom_range(bta_pkg::WORDS * bta_pkg::BITS_PER_WORD,
			2 ** bta_pkg::TAG_W - 1));
	endfunction

	// Receiver: stall density changes over time, with one long hold-off
	// while the sender keeps offering requests.
	initial begin
		int  stall_pct;
		int  pattern_left;
		bit  hold_done;
		stall_pct    = 0;
		pattern_left = 0;
		hold_done    = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && requests_sent >= HOLD_AFTER) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			if (pattern_left == 0) begin
				case ($urandom_range(4))
					0, 1: stall_pct = 0;
					2:    stall_pct = 25;
					3:    stall_pct = 60;
					default: stall_pct = 90;
				endcase
				pattern_left = $urandom_range(20, 200);
			end
			pattern_left--;
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Hard limit on the run time.
	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Stimulus.
	initial begin
		traffic_mode_t mode;
		int            phase_len;
		int            alloc_pct;
		int            random_sent;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: first grants, double free, edges of the tag range.
		send_request(bta_pkg::OP_ALLOC, '1);
		send_request(bta_pkg::OP_ALLOC, '0);
		send_request(bta_pkg::OP_ALLOC, bta_pkg::TAG_W'(16));
		send_request(bta_pkg::OP_FREE, '0);
		send_request(bta_pkg::OP_FREE, '0);
		send_request(bta_pkg::OP_ALLOC, bta_pkg::TAG_W'(512));
		send_request(bta_pkg::OP_FREE,
			bta_pkg::TAG_W'(bta_pkg::WORDS * bta_pkg::BITS_PER_WORD - 1));
		send_request(bta_pkg::OP_FREE,
			bta_pkg::TAG_W'(bta_pkg::WORDS * bta_pkg::BITS_PER_WORD));
		send_request(bta_pkg::OP_FREE, '1);
		send_request(bta_pkg::OP_FREE, bta_pkg::TAG_W'(512));
		send_request(bta_pkg::OP_FREE, bta_pkg::TAG_W'(15));
		send_request(bta_pkg::OP_FREE, bta_pkg::TAG_W'(1));
		send_request(bta_pkg::OP_ALLOC, bta_pkg::TAG_W'(341));
		send_request(bta_pkg::OP_ALLOC, bta_pkg::TAG_W'(682));
		send_request(bta_pkg::OP_FREE, bta_pkg::TAG_W'(2));
		send_request(bta_pkg::OP_ALLOC, '0);
		send_request(bta_pkg::OP_FREE, bta_pkg::TAG_W'(240));
		send_request(bta_pkg::OP_FREE, bta_pkg::TAG_W'(768));

		// Random: the first phase fills the map past full, later phases
		// drain, refill and mix requests at random.
		random_sent = 0;
		mode        = MODE_FILL;
		phase_len   = 320;
		while (random_sent < RANDOM_ITEMS) begin
			case (mode)
				MODE_FILL:  alloc_pct = 95;
				MODE_DRAIN: alloc_pct = 10;
				default:    alloc_pct = 50;
			endcase
			for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
				if ($urandom_range(99) < alloc_pct) begin
					send_request(bta_pkg::OP_ALLOC, bta_pkg::TAG_W'($urandom));
				end else begin
					send_request(bta_pkg::OP_FREE, pick_free_tag(85));
				end
				random_sent++;
			end
			case ($urandom_range(2))
				0:       mode = MODE_FILL;
				1:       mode = MODE_DRAIN;
				default: mode = MODE_MIXED;
			endcase
			phase_len = $urandom_range(50, 300);
		end
		in_valid <= 1'b0;

		// Wait for every predicted result, then a little longer for strays.
		while (grants_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && grants_pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
